### hw/rtl/dpr_pkg.sv
package dpr_pkg;

  localparam logic [7:0] BYTE_INTR  = 8'h03;
  localparam logic [7:0] BYTE_OPEN  = 8'h24;
  localparam logic [7:0] BYTE_CLOSE = 8'h23;
  localparam int unsigned HEX_RADIX = 16;

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_BAD     = 2'd2;
  localparam logic [1:0] KIND_INTR    = 2'd3;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] payload_byte;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
  } result_t;

  typedef struct packed {
    logic       bad;
    logic [3:0] nibble;
  } hex_t;

  // non-hex bytes decode as nibble zero with bad set
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.bad    = 1'b0;
    h.nibble = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.nibble = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.nibble = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.bad = 1'b1;
    end
    return h;
  endfunction

endpackage

### hw/rtl/dpr_in_stage.sv
module dpr_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       byte_valid,
  output logic [7:0] byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;

  assign in_ready   = !valid_r || take;
  assign valid_nxt  = (in_valid && in_ready) ? 1'b1 : (take ? 1'b0 : valid_r);
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_rx_byte;
    end
  end

endmodule

### hw/rtl/dpr_parser.sv
module dpr_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  output logic             res_valid,
  output dpr_pkg::result_t res
);

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_HIGH    = 2'd2;
  localparam logic [1:0] PH_LOW     = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [3:0] high_r, high_nxt;
  logic       high_bad_r, high_bad_nxt;

  dpr_pkg::hex_t hex;
  logic [7:0]    rsum;

  assign hex  = dpr_pkg::hex_decode(rx_byte);
  assign rsum = {high_r, hex.nibble};

  always_comb begin
    phase_nxt    = phase_r;
    sum_nxt      = sum_r;
    high_nxt     = high_r;
    high_bad_nxt = high_bad_r;
    res_valid    = 1'b0;
    res          = '0;
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == dpr_pkg::BYTE_INTR) begin
          res_valid      = 1'b1;
          res.event_kind = dpr_pkg::KIND_INTR;
        end else if (rx_byte == dpr_pkg::BYTE_OPEN) begin
          phase_nxt = PH_PAYLOAD;
          sum_nxt   = 8'd0;
        end
      end
      PH_PAYLOAD: begin
        if (rx_byte == dpr_pkg::BYTE_CLOSE) begin
          phase_nxt = PH_HIGH;
        end else begin
          sum_nxt          = sum_r + rx_byte;
          res_valid        = 1'b1;
          res.event_kind   = dpr_pkg::KIND_PAYLOAD;
          res.payload_byte = rx_byte;
        end
      end
      PH_HIGH: begin
        high_nxt     = hex.nibble;
        high_bad_nxt = hex.bad;
        phase_nxt    = PH_LOW;
      end
      PH_LOW: begin
        res_valid        = 1'b1;
        res.computed_sum = sum_r;
        res.received_sum = rsum;
        res.event_kind   = (high_bad_r || hex.bad || rsum != sum_r) ?
                           dpr_pkg::KIND_BAD : dpr_pkg::KIND_GOOD;
        phase_nxt        = PH_IDLE;
        sum_nxt          = 8'd0;
        high_nxt         = 4'd0;
        high_bad_nxt     = 1'b0;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      sum_r      <= 8'd0;
      high_r     <= 4'd0;
      high_bad_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      sum_r      <= sum_nxt;
      high_r     <= high_nxt;
      high_bad_r <= high_bad_nxt;
    end
  end

endmodule

### hw/rtl/dpr_out_stage.sv
module dpr_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  dpr_pkg::result_t res,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_event_kind,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_computed_sum,
  output logic [7:0]       out_received_sum
);

  logic             valid_r;
  logic             valid_nxt;
  dpr_pkg::result_t res_r;

  // free also when the held transaction leaves this cycle
  assign free      = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_event_kind   = res_r.event_kind;
  assign out_payload_byte = res_r.payload_byte;
  assign out_computed_sum = res_r.computed_sum;
  assign out_received_sum = res_r.received_sum;

endmodule

### hw/rtl/debug_packet_receiver_core.sv
// Byte-serial receiver for debug-link packets of the form $<payload>#hh. One byte is taken per
// cycle while the output is not stalled and gives at most one result: a payload byte, a good or
// bad packet verdict after the two checksum digits, or an interrupt request for a 0x03 byte
// outside a packet. Each byte passes an input register, a parse step that decodes the byte and
// updates the packet state, and an output register. Throughput is one byte per cycle as long as
// out_ready stays high; a byte waits in the input register only while the output register holds
// a result that has not been taken.
module debug_packet_receiver_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_event_kind,
  output logic [7:0] out_payload_byte,
  output logic [7:0] out_computed_sum,
  output logic [7:0] out_received_sum
);

  logic             byte_valid;
  logic [7:0]       byte_data;
  logic             out_free;
  logic             step;
  logic             res_valid;
  dpr_pkg::result_t res;

  assign step = byte_valid && out_free;

  dpr_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  dpr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .rx_byte   (byte_data),
    .res_valid (res_valid),
    .res       (res)
  );

  dpr_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (step && res_valid),
    .res              (res),
    .free             (out_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_payload_byte (out_payload_byte),
    .out_computed_sum (out_computed_sum),
    .out_received_sum (out_received_sum)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int IDLE_LIMIT = 600;
  localparam int RANDOM_ITEMS = 650;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAYLOAD,
    ST_HIGH,
    ST_LOW
  } rx_phase_t;

  // predicts the receiver and keeps the results still owed by the block
  class packet_scoreboard;
    dpr_pkg::result_t expected_q[$];
    int        errors;
    int        n_payload;
    int        n_good;
    int        n_bad;
    int        n_intr;
    rx_phase_t phase;
    logic [7:0] sum;
    logic [3:0] hi_nib;
    logic       hi_bad;

    function new();
      errors    = 0;
      n_payload = 0;
      n_good    = 0;
      n_bad     = 0;
      n_intr    = 0;
      phase     = ST_IDLE;
      sum       = '0;
      hi_nib    = '0;
      hi_bad    = 1'b0;
    endfunction

    // {not_hex, nibble}; nibble is zero for a non-hex byte
    static function logic [4:0] hex_digit(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b0, 4'(c - 8'h30)};
      if (c >= 8'h41 && c <= 8'h46) return {1'b0, 4'(c - 8'h37)};
      if (c >= 8'h61 && c <= 8'h66) return {1'b0, 4'(c - 8'h57)};
      return 5'b1_0000;
    endfunction

    // returns 0 when the byte is dropped outside a packet
    function bit note_byte(logic [7:0] b);
      dpr_pkg::result_t r;
      logic [4:0]       d;
      logic             bad;
      r = '0;
      case (phase)
        ST_IDLE: begin
          if (b == dpr_pkg::BYTE_INTR) begin
            r.event_kind = dpr_pkg::KIND_INTR;
            expected_q.push_back(r);
            return 1'b1;
          end
          if (b == dpr_pkg::BYTE_OPEN) begin
            phase = ST_PAYLOAD;
            sum   = '0;
            return 1'b1;
          end
          return 1'b0;
        end
        ST_PAYLOAD: begin
          if (b == dpr_pkg::BYTE_CLOSE) begin
            phase = ST_HIGH;
          end else begin
            sum = sum + b;
            r.event_kind   = dpr_pkg::KIND_PAYLOAD;
            r.payload_byte = b;
            expected_q.push_back(r);
          end
        end
        ST_HIGH: begin
          d      = hex_digit(b);
          hi_bad = d[4];
          hi_nib = d[3:0];
          phase  = ST_LOW;
        end
        default: begin
          d = hex_digit(b);
          r.received_sum = {hi_nib, d[3:0]};
          r.computed_sum = sum;
          bad = hi_bad | d[4] | (r.received_sum != sum);
          r.event_kind = bad ? dpr_pkg::KIND_BAD : dpr_pkg::KIND_GOOD;
          expected_q.push_back(r);
          phase  = ST_IDLE;
          sum    = '0;
          hi_nib = '0;
          hi_bad = 1'b0;
        end
      endcase
      return 1'b1;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(dpr_pkg::result_t got);
      dpr_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result kind %0d with nothing expected", got.event_kind));
        return;
      end
      want = expected_q.pop_front();
      if (got.event_kind !== want.event_kind)
        report_mismatch($sformatf("event_kind %0d, expected %0d",
                                  got.event_kind, want.event_kind));
      if (got.payload_byte !== want.payload_byte)
        report_mismatch($sformatf("payload_byte %h, expected %h",
                                  got.payload_byte, want.payload_byte));
      if (got.computed_sum !== want.computed_sum)
        report_mismatch($sformatf("computed_sum %h, expected %h",
                                  got.computed_sum, want.computed_sum));
      if (got.received_sum !== want.received_sum)
        report_mismatch($sformatf("received_sum %h, expected %h",
                                  got.received_sum, want.received_sum));
      case (want.event_kind)
        dpr_pkg::KIND_PAYLOAD: n_payload++;
        dpr_pkg::KIND_GOOD:    n_good++;
        dpr_pkg::KIND_BAD:     n_bad++;
        default:               n_intr++;
      endcase
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] out_event_kind;
  logic [7:0] out_payload_byte;
  logic [7:0] out_computed_sum;
  logic [7:0] out_received_sum;

  packet_scoreboard sb = new();
  int  bytes_sent = 0;
  int  items_counted = 0;
  int  idle_cycles = 0;
  bit  steady = 1'b0;

  debug_packet_receiver_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_event_kind   (out_event_kind),
    .out_payload_byte (out_payload_byte),
    .out_computed_sum (out_computed_sum),
    .out_received_sum (out_received_sum)
  );

  always #10 clk = ~clk;

  // steady stretches run both sides back to back
  function automatic int draw_wait();
    if (steady) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic upper;
    upper = 1'($urandom_range(0, 1));
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h37 : 8'h57) + n;
  endfunction

  // mostly bytes just outside the digit and letter ranges
  function automatic logic [7:0] non_hex_char();
    logic [7:0] edges[6];
    logic [7:0] c;
    logic [4:0] d;
    edges = '{8'h2f, 8'h3a, 8'h40, 8'h47, 8'h60, 8'h67};
    if ($urandom_range(0, 1)) return edges[$urandom_range(0, 5)];
    do begin
      c = 8'($urandom_range(0, 255));
      d = packet_scoreboard::hex_digit(c);
    end while (!d[4]);
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (sb.note_byte(b)) items_counted++;
  endtask

  task automatic send_packet();
    int         mode;
    int         len;
    logic [7:0] b;
    logic [7:0] total;
    logic [7:0] hi_c;
    logic [7:0] lo_c;
    mode  = $urandom_range(0, 9);
    len   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(0, 6);
    total = '0;
    send_byte(dpr_pkg::BYTE_OPEN);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 7) == 0)
        b = $urandom_range(0, 1) ? dpr_pkg::BYTE_INTR : dpr_pkg::BYTE_OPEN;
      else
        b = 8'($urandom_range(0, 255));
      if (b == dpr_pkg::BYTE_CLOSE) b = dpr_pkg::BYTE_OPEN;
      total = total + b;
      send_byte(b);
    end
    // occasionally leave the packet open so the next one lands in its payload
    if ($urandom_range(0, 29) == 0) return;
    if (mode == 6) total = total ^ 8'($urandom_range(1, 255));
    hi_c = hex_char(total[7:4]);
    lo_c = hex_char(total[3:0]);
    if (mode == 7 || mode == 9) hi_c = non_hex_char();
    if (mode == 8 || mode == 9) lo_c = non_hex_char();
    send_byte(dpr_pkg::BYTE_CLOSE);
    send_byte(hi_c);
    send_byte(lo_c);
  endtask

  task automatic send_noise();
    int         n;
    int         pick;
    logic [7:0] b;
    n = $urandom_range(1, 3);
    repeat (n) begin
      pick = $urandom_range(0, 2);
      if (pick == 0) b = dpr_pkg::BYTE_INTR;
      else if (pick == 1) b = dpr_pkg::BYTE_CLOSE;
      else begin
        b = 8'($urandom_range(0, 255));
        if (b == dpr_pkg::BYTE_OPEN) b = dpr_pkg::BYTE_INTR;
      end
      send_byte(b);
    end
  endtask

  // directed: interrupt and drops outside, control bytes inside, both digit cases,
  // empty payload, non-hex high and low digit, wrong checksum
  logic [7:0] directed_bytes[27] = '{
    8'h03, 8'h41, 8'h24, 8'h00, 8'hff, 8'h03, 8'h24, 8'h23, 8'h32, 8'h36,
    8'h24, 8'hab, 8'h23, 8'h61, 8'h42,
    8'h24, 8'h23, 8'h47, 8'h30,
    8'h24, 8'h23, 8'h30, 8'h7a,
    8'h24, 8'h23, 8'h66, 8'h46
  };

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_event_kind, out_payload_byte, out_computed_sum, out_received_sum});
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, sb.expected_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // result side: a fresh stall before each transaction
  initial begin
    int stall;
    wait (rst_n);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);

    items_counted = 0;
    while (items_counted < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) steady = !steady;
      if ($urandom_range(0, 3) == 0) send_noise();
      send_packet();
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
    $display("sent %0d bytes; checked %0d payload, %0d good, %0d bad, %0d interrupt results",
             bytes_sent, sb.n_payload, sb.n_good, sb.n_bad, sb.n_intr);
    $display("%0d mismatches", sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/dpr_pkg.sv
hw/rtl/dpr_in_stage.sv
hw/rtl/dpr_parser.sv
hw/rtl/dpr_out_stage.sv
hw/rtl/debug_packet_receiver_core.sv
sim/tb_top.sv
